// File: hdl/oets_pkg.sv
// Shared constants and control/status types for the odd-even transposition sorter.
package oets_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 16;

  typedef struct packed {
    logic load;
    logic sort;
    logic shift;
  } oets_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic emit_last;
  } oets_status_t;

endpackage

// File: hdl/oets_dp.sv
// Datapath: element registers, compare-exchange network, count, phase counter.
module oets_dp import oets_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  oets_cmd_t                cmd,
  output oets_status_t             status,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = CW + 1;

  logic signed [DATA_W-1:0] elem_r   [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] elem_nxt [MAX_ELEMENTS];
  logic [CW-1:0]            count_r, count_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [PW-1:0]            phase_r, phase_nxt;
  logic                     full;
  logic [PW-1:0]            phase_end;

  assign full      = (count_r == CW'(MAX_ELEMENTS));
  assign phase_end = {count_r, 1'b0} - PW'(1);

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem_nxt[i] = elem_r[i];
    end
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    phase_nxt   = phase_r;
    if (cmd.load) begin
      phase_nxt = '0;
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          if (count_r == CW'(i)) begin
            elem_nxt[i] = in_value;
          end
        end
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.sort) begin
      phase_nxt = phase_r + PW'(1);
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        if ((i[0] == phase_r[0]) && (CW'(i + 1) < count_r) && (elem_r[i+1] < elem_r[i])) begin
          elem_nxt[i]   = elem_r[i+1];
          elem_nxt[i+1] = elem_r[i];
        end
      end
    end
    if (cmd.shift) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        elem_nxt[i] = elem_r[i+1];
      end
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      elem_r[i] <= elem_nxt[i];
    end
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      phase_r   <= '0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      phase_r   <= phase_nxt;
    end
  end

  assign status.sort_done = (phase_r == phase_end);
  assign status.emit_last = (count_r == CW'(1));

  assign out_sorted_value = elem_r[0];
  assign out_final_res    = (count_r == CW'(1));
  assign out_overflow     = dropped_r;

endmodule

// File: hdl/oets_ctrl.sv
// Controller: load / sort / emit sequencing and handshake control.
module oets_ctrl import oets_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  oets_status_t status,
  output oets_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  assign cmd.load  = in_valid & in_ready_r;
  assign cmd.sort  = (state_r == ST_SORT);
  assign cmd.shift = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_valid && in_ready_r && in_last) begin
            state_r    <= ST_SORT;
            in_ready_r <= 1'b0;
          end
        end
        ST_SORT: begin
          if (status.sort_done) begin
            state_r     <= ST_EMIT;
            out_valid_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready && status.emit_last) begin
            state_r     <= ST_LOAD;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_LOAD;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: hdl/odd_even_transposition_sorter_core.sv
// Odd-even transposition sorter, top level.
// Collects a set of signed values one transfer per cycle until a transfer with
// in_last, then sorts them by odd-even transposition and streams them out in
// ascending order, out_final_res on the last one. The sort runs one
// compare-exchange phase per cycle over all pairs of that phase's parity at
// once, and a set of N stored values is emitted as N transfers. Values beyond
// MAX_ELEMENTS are dropped and out_overflow is set on every result of that set.
// A new set is accepted once the last result has transferred.
module odd_even_transposition_sorter_core import oets_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  oets_cmd_t    cmd;
  oets_status_t status;

  oets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  oets_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for odd_even_transposition_sorter_core: directed and random sets against a local sort.
module testbench;
  import oets_pkg::*;

  localparam int SET_CAP     = MAX_ELEMENTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 250;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  final_res;
    logic  overflow;
  } sorted_result_t;

  localparam elem_t VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam elem_t VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  elem_t in_value  = '0;
  logic  in_last   = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  elem_t out_sorted_value;
  logic  out_final_res;
  logic  out_overflow;

  // local copy of the block's set store
  elem_t set_store[SET_CAP];
  int    set_len     = 0;
  logic  set_dropped = 1'b0;
  sorted_result_t expected_sorted[$];

  elem_t set_values[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  int mismatches    = 0;
  int sets_done     = 0;
  int values_in     = 0;
  int results_seen  = 0;
  int overflow_sets = 0;
  int stall_cycles  = 0;

  odd_even_transposition_sorter_core u_dut (.*);

  always #4 clk = ~clk;

  // store one value; on the last one sort by odd-even transposition and queue the results
  task automatic absorb_element(input elem_t value, input logic last);
    elem_t tmp;
    int n;
    sorted_result_t r;
    if (set_len < SET_CAP) begin
      set_store[set_len] = value;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      n = set_len;
      for (int rnd = 0; rnd < n; rnd++) begin
        for (int ph = 0; ph < 2; ph++) begin
          for (int j = ph; j + 1 < n; j += 2) begin
            if (set_store[j+1] < set_store[j]) begin
              tmp            = set_store[j];
              set_store[j]   = set_store[j+1];
              set_store[j+1] = tmp;
            end
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        r.value     = set_store[k];
        r.final_res = (k == n - 1);
        r.overflow  = set_dropped;
        expected_sorted.push_back(r);
      end
      sets_done++;
      if (set_dropped) overflow_sets++;
      set_len     = 0;
      set_dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    sorted_result_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_sorted.size() == 0) begin
          $error("unexpected result transfer: sorted_value %0d", out_sorted_value);
          mismatches++;
        end else begin
          exp_r = expected_sorted.pop_front();
          if (out_sorted_value !== exp_r.value) begin
            $error("sorted_value: expected %0d, got %0d", exp_r.value, out_sorted_value);
            mismatches++;
          end
          if (out_final_res !== exp_r.final_res) begin
            $error("final_res: expected %0b, got %0b", exp_r.final_res, out_final_res);
            mismatches++;
          end
          if (out_overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, out_overflow);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_element(in_value, in_last);
        values_in++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
          $display("[odd_even_transposition_sorter_core] ERROR");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold when requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // entered and left just after a falling edge
  task automatic send_item(input elem_t value, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    in_last  <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_set();
    for (int i = 0; i < set_values.size(); i++)
      send_item(set_values[i], i == set_values.size() - 1);
  endtask

  function automatic elem_t pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return elem_t'($urandom_range(0, 8)) - 4;
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic int pick_set_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(SET_CAP - 2, SET_CAP + 3);
    return $urandom_range(1, 6);
  endfunction

  task automatic fill_random_set(input int len);
    set_values.delete();
    repeat (len) set_values.push_back(pick_value());
  endtask

  task automatic test_directed();
    send_idle_pct = 33;
    recv_idle_pct = 46;
    set_values = '{elem_t'(0)};
    send_set();
    set_values = '{VAL_MAX, VAL_MIN, elem_t'(-1), elem_t'(0), elem_t'(1), VAL_MAX};
    send_set();
    set_values = '{elem_t'(7), elem_t'(-7), elem_t'(7)};
    send_set();
    // one more than capacity, reverse order: the last value is dropped
    set_values.delete();
    for (int i = 0; i <= SET_CAP; i++) set_values.push_back(elem_t'(100 * (8 - i)));
    send_set();
  endtask

  task automatic test_random_sets(input int s_pct, input int r_pct, input int n_values);
    int sent;
    int len;
    sent          = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (sent < n_values) begin
      len = pick_set_len();
      fill_random_set(len);
      send_set();
      sent += len;
    end
  endtask

  // output held off long enough that the block stalls its input
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    fill_random_set(5);
    send_set();
    fill_random_set(SET_CAP);
    send_set();
    fill_random_set(4);
    send_set();
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (expected_sorted.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d values in %0d sets (%0d over capacity), %0d sorted results checked",
             values_in, sets_done, overflow_sets, results_seen);
    $display("stalls: sender/receiver 33/46, then 46/33, then none, plus one long output hold");
    if (mismatches == 0) begin
      $display("[odd_even_transposition_sorter_core] OK");
    end else begin
      $display("[odd_even_transposition_sorter_core] ERROR");
    end
    $finish;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_sets(33, 46, 55);
    test_random_sets(46, 33, 55);
    test_random_sets(0, 0, 50);
    test_output_hold();
    finish_run();
  end

endmodule

// File: files.f
hdl/oets_pkg.sv
hdl/oets_dp.sv
hdl/oets_ctrl.sv
hdl/odd_even_transposition_sorter_core.sv
tb/testbench.sv
